// File: rtl/core/rspe_pkg.sv
package rspe_pkg;

  localparam int SYM_W          = 8;
  localparam int DEF_MAX_PARITY = 32;
  localparam int PLEN_W         = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;
  localparam int LEN_W          = 8;

  localparam logic [PLEN_W-1:0]    RESET_PLEN   = 6'd16;
  localparam logic [SYM_W-1:0]     RESET_POLY   = 8'd29;
  localparam logic [LEN_W-1:0]     SYMBOL_LIMIT = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_PARITY_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY    = 1'd1;

  // handshake from the remainder stage to the output buffer
  typedef struct packed {
    logic load;
    logic err;
  } done_t;

  // multiply modulo x^8 + poly
  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b,
                                               input logic [SYM_W-1:0] poly);
    logic [SYM_W-1:0] x;
    logic [SYM_W-1:0] acc;
    logic             carry;
    x   = a;
    acc = '0;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) acc = acc ^ x;
      carry = x[SYM_W-1];
      x     = {x[SYM_W-2:0], 1'b0};
      if (carry) x = x ^ poly;
    end
    return acc;
  endfunction

endpackage

// File: rtl/core/reed_solomon_parity_encoder.sv
// systematic reed-solomon parity encoder over gf(2^8), generator prod (x - 2^i) for
// i = 0..L-1, with L the parity length register (0 acts as 1, values above MAX_PARITY
// act as MAX_PARITY) and the field polynomial x^8 + field_polynomial_low. message bytes
// enter highest degree first with s_tuser = 1; s_tlast marks the last item of a message,
// and an item with s_tuser = 0 and s_tlast = 1 ends an empty message. each message byte
// updates all L remainder cells in parallel from the input register.
// the end of a message hands the remainder to an output buffer, which sends L parity
// items (highest degree first, m_tlast on the last) one per cycle while m_tready is
// high, as the next message streams in; an end-of-message item also waits while the
// previous parity run still drains. if the message plus L exceeds 255 symbols a single
// item with m_tdata = 0, m_tlast = 1 and m_tuser = 1 is sent instead. after reset and
// after every configuration write the generator is rebuilt by one factor per cycle,
// during which no item is processed (one item may wait in the input register)
module reed_solomon_parity_encoder #(
  parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PARITY
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: index 0 parity_length, index 1 field_polynomial_low
  input  logic                            cfg_we,
  input  logic [rspe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rspe_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rspe_pkg::SYM_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                            s_tuser,   // [0] byte_valid
  input  logic                            s_tlast,   // end_of_message
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rspe_pkg::SYM_W-1:0]      m_tdata,   // [7:0] parity_byte
  output logic                            m_tuser,   // [0] status
  output logic                            m_tlast    // last_of_run
);

  localparam int CNT_W = $clog2(MAX_PARITY + 1);

  // effective parity length and field polynomial
  logic [CNT_W-1:0]           eff;
  logic [rspe_pkg::SYM_W-1:0] poly;
  // generator coefficients below the leading one (the leading coefficient is always 1),
  // entry k holds the coefficient of x^(L-1-k)
  logic [rspe_pkg::SYM_W-1:0] gen [MAX_PARITY];
  logic                       building;
  // remainder after the current item, loaded into the output buffer at end of message
  logic [rspe_pkg::SYM_W-1:0] rem_next [MAX_PARITY];
  rspe_pkg::done_t            done;
  logic                       blocked;

  // configuration registers and generator rebuild
  rspe_gen #(
    .MAX_PARITY (MAX_PARITY),
    .CNT_W      (CNT_W)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff),
    .poly      (poly),
    .gen       (gen),
    .building  (building)
  );

  // input register, remainder cells and length tracking
  rspe_rem #(
    .MAX_PARITY (MAX_PARITY),
    .CNT_W      (CNT_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .eff      (eff),
    .poly     (poly),
    .gen      (gen),
    .building (building),
    .blocked  (blocked),
    .done     (done),
    .rem_next (rem_next)
  );

  // parity run buffer, drains one item per cycle while m_tready is high
  rspe_obuf #(
    .MAX_PARITY (MAX_PARITY),
    .CNT_W      (CNT_W)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .done     (done),
    .par      (rem_next),
    .eff      (eff),
    .blocked  (blocked),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/core/rspe_gen.sv
module rspe_gen #(
  parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PARITY,
  parameter int CNT_W      = $clog2(MAX_PARITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rspe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rspe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [CNT_W-1:0]                 eff,
  output logic [rspe_pkg::SYM_W-1:0]       poly,
  output logic [rspe_pkg::SYM_W-1:0]       gen [MAX_PARITY],
  output logic                             building
);

  logic [rspe_pkg::PLEN_W-1:0] plen;
  logic                        build_init;
  logic [CNT_W-1:0]            build_left;
  logic [rspe_pkg::SYM_W-1:0]  root;

  // clamp parity length to 1..MAX_PARITY
  always_comb begin
    if (plen == '0) eff = CNT_W'(1);
    else if ({1'b0, plen} > (rspe_pkg::PLEN_W + 1)'(MAX_PARITY)) eff = CNT_W'(MAX_PARITY);
    else eff = CNT_W'(plen);
  end

  assign building = build_init | (build_left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      plen       <= rspe_pkg::RESET_PLEN;
      poly       <= rspe_pkg::RESET_POLY;
      build_init <= 1'b1;
      build_left <= '0;
    end else begin
      if (build_init) begin
        build_init <= 1'b0;
        build_left <= eff;
      end else if (build_left != '0) begin
        build_left <= build_left - CNT_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rspe_pkg::REG_PARITY_LENGTH: begin
            plen       <= cfg_data[rspe_pkg::PLEN_W-1:0];
            build_init <= 1'b1;
          end
          rspe_pkg::REG_FIELD_POLY: begin
            poly       <= cfg_data[rspe_pkg::SYM_W-1:0];
            build_init <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // one factor (x - root) multiplied in per cycle, all coefficients at once
  always_ff @(posedge clk) begin
    if (build_init) begin
      root <= rspe_pkg::SYM_W'(1);
      for (int j = 0; j < MAX_PARITY; j++) gen[j] <= '0;
    end else if (build_left != '0) begin
      root   <= rspe_pkg::gf_mul(root, rspe_pkg::SYM_W'(2), poly);
      gen[0] <= gen[0] ^ root;
      for (int j = 1; j < MAX_PARITY; j++)
        gen[j] <= gen[j] ^ rspe_pkg::gf_mul(root, gen[j-1], poly);
    end
  end

endmodule

// File: rtl/core/rspe_rem.sv
module rspe_rem #(
  parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PARITY,
  parameter int CNT_W      = $clog2(MAX_PARITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rspe_pkg::SYM_W-1:0]  s_tdata,
  input  logic                        s_tuser,
  input  logic                        s_tlast,
  input  logic [CNT_W-1:0]            eff,
  input  logic [rspe_pkg::SYM_W-1:0]  poly,
  input  logic [rspe_pkg::SYM_W-1:0]  gen [MAX_PARITY],
  input  logic                        building,
  input  logic                        blocked,
  output rspe_pkg::done_t             done,
  output logic [rspe_pkg::SYM_W-1:0]  rem_next [MAX_PARITY]
);

  logic                         in_valid;
  logic [rspe_pkg::SYM_W-1:0]   in_data;
  logic                         in_bv;
  logic                         in_eom;
  logic                         consume;

  logic [rspe_pkg::SYM_W-1:0]   rem     [MAX_PARITY];
  logic [rspe_pkg::SYM_W-1:0]   rem_upd [MAX_PARITY];
  logic [rspe_pkg::SYM_W-1:0]   fb;
  logic [rspe_pkg::LEN_W-1:0]   len;
  logic [rspe_pkg::LEN_W-1:0]   len_next;
  logic                         ovf;
  logic                         ovf_next;
  logic                         err;

  assign consume  = in_valid & ~building & ~(in_eom & blocked);
  assign s_tready = ~in_valid | consume;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_tvalid & s_tready) in_valid <= 1'b1;
    else if (consume) in_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid & s_tready) begin
      in_data <= s_tdata;
      in_bv   <= s_tuser;
      in_eom  <= s_tlast;
    end
  end

  assign fb = in_data ^ rem[0];

  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
    logic [rspe_pkg::SYM_W-1:0] upper;
    logic [rspe_pkg::SYM_W-1:0] prod;
    if (j + 1 < MAX_PARITY) begin : g_up
      assign upper = rem[j+1];
    end else begin : g_top
      assign upper = '0;
    end
    assign prod = rspe_pkg::gf_mul(gen[j], fb, poly);
    always_comb begin
      if (CNT_W'(j + 1) < eff) rem_upd[j] = upper ^ prod;
      else if (CNT_W'(j + 1) == eff) rem_upd[j] = prod;
      else rem_upd[j] = rem[j];
      rem_next[j] = in_bv ? rem_upd[j] : rem[j];
    end
  end

  always_comb begin
    len_next = len;
    ovf_next = ovf;
    if (in_bv) begin
      if (len == rspe_pkg::SYMBOL_LIMIT) ovf_next = 1'b1;
      else len_next = len + rspe_pkg::LEN_W'(1);
    end
    err = ovf_next |
          (({1'b0, len_next} + (rspe_pkg::LEN_W + 1)'(eff)) >
           {1'b0, rspe_pkg::SYMBOL_LIMIT});
  end

  assign done.load = consume & in_eom;
  assign done.err  = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      for (int j = 0; j < MAX_PARITY; j++) rem[j] <= '0;
    end else if (consume) begin
      if (in_eom) begin
        len <= '0;
        ovf <= 1'b0;
        for (int j = 0; j < MAX_PARITY; j++) rem[j] <= '0;
      end else begin
        len <= len_next;
        ovf <= ovf_next;
        for (int j = 0; j < MAX_PARITY; j++) rem[j] <= rem_next[j];
      end
    end
  end

endmodule

// File: rtl/core/rspe_obuf.sv
module rspe_obuf #(
  parameter int MAX_PARITY = rspe_pkg::DEF_MAX_PARITY,
  parameter int CNT_W      = $clog2(MAX_PARITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rspe_pkg::done_t             done,
  input  logic [rspe_pkg::SYM_W-1:0]  par [MAX_PARITY],
  input  logic [CNT_W-1:0]            eff,
  output logic                        blocked,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rspe_pkg::SYM_W-1:0]  m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);

  logic [CNT_W-1:0]           left;
  logic                       err;
  logic [rspe_pkg::SYM_W-1:0] held [MAX_PARITY];
  logic                       pop;

  assign m_tvalid = left != '0;
  assign m_tlast  = left == CNT_W'(1);
  assign m_tdata  = held[0];
  assign m_tuser  = err;
  assign pop      = m_tvalid & m_tready;
  // a new run may load only when no run is pending or the last item of the current run leaves
  assign blocked  = (left > CNT_W'(1)) | ((left == CNT_W'(1)) & ~m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      err  <= 1'b0;
    end else if (done.load) begin
      left <= done.err ? CNT_W'(1) : eff;
      err  <= done.err;
    end else if (pop) begin
      left <= left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (done.load) begin
      for (int i = 0; i < MAX_PARITY; i++) held[i] <= done.err ? '0 : par[i];
    end else if (pop) begin
      for (int i = 0; i + 1 < MAX_PARITY; i++) held[i] <= held[i+1];
      held[MAX_PARITY-1] <= '0;
    end
  end

endmodule
